// ===== rtl/core/nfcr_pkg.sv =====
// ============================================================================
// nfcr_pkg
// Shared types and constants of the NAND flash controller register front end.
// ============================================================================
`default_nettype none

package nfcr_pkg;

    localparam logic [31:0] IpBase     = 32'h83FD_B000;
    localparam logic [31:0] BufWinBase = 32'hCFFF_1000;

    // buffer window offsets, relative to the window start
    localparam logic [11:0] BufCmd     = 12'hE00;
    localparam logic [11:0] BufAddrLo  = 12'hE04;
    localparam logic [11:0] BufAddrHi  = 12'hE30;
    localparam logic [11:0] BufCfg1    = 12'hE34;
    localparam logic [11:0] BufEcc     = 12'hE38;
    localparam logic [11:0] BufStat    = 12'hE3C;
    localparam logic [11:0] BufLaunch  = 12'hE40;

    // register window offsets
    localparam logic [31:0] RegWp      = 32'h00;
    localparam logic [31:0] RegUnlkLo  = 32'h04;
    localparam logic [31:0] RegUnlkHi  = 32'h20;
    localparam logic [31:0] RegCfg2    = 32'h24;
    localparam logic [31:0] RegCfg3    = 32'h28;
    localparam logic [31:0] RegIrq     = 32'h2C;
    localparam logic [31:0] RegBusErr  = 32'h30;
    localparam logic [31:0] RegDelay   = 32'h34;

    // NAND commands
    localparam logic [7:0] CmdRead     = 8'h00;
    localparam logic [7:0] CmdReadId   = 8'h90;
    localparam logic [7:0] CmdReadGo   = 8'h30;
    localparam logic [7:0] CmdStatus   = 8'h70;
    localparam logic [7:0] CmdCacheSeq = 8'h31;
    localparam logic [7:0] CmdCacheEnd = 8'h3F;
    localparam logic [7:0] CmdReset    = 8'hFF;

    // data output selectors
    localparam logic [2:0] FdoPage     = 3'd1;
    localparam logic [2:0] FdoId       = 3'd2;
    localparam logic [2:0] FdoStatus   = 3'd4;

    localparam logic [7:0] StatusByte  = 8'hE0;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_READ  = 3'd1,
        OP_PROG  = 3'd2,
        OP_ERASE = 3'd3,
        OP_ID    = 3'd4
    } flash_op_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_ACCESS = 2'd1,
        ERR_LAUNCH = 2'd2
    } err_t;

endpackage

`default_nettype wire

// ===== rtl/core/nfcr_ram.sv =====
// ============================================================================
// nfcr_ram
// Generic single-port RAM with registered read and read enable.
// ============================================================================
`default_nettype none

module nfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire logic [WIDTH-1:0]           wdata,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nand_flash_controller_regs.sv =====
// ============================================================================
// nand_flash_controller_regs
// Register front end of a NAND flash controller with launch sequencer.
// ============================================================================
// Input channel (in_valid/in_ready) carries one bus transaction: action,
// bus_address, write_data, width_bytes. Output channel (out_valid/out_ready)
// returns one result transaction per input: read_data, flash_op,
// flash_offset, error_code.
// Results are registered: a transaction accepted at one edge shows its result
// right after that edge. Throughput is one transaction per cycle while
// in_ready is high. The spare buffer sits in four byte-lane RAMs with
// registered read; all accesses to it are issued at the accepting edge, so
// successive transactions see each other in order without forwarding.
// A single output register parts the two sides: a new transaction is taken
// while the result waits, as long as out_ready is high or the output slot
// is empty. When the receiver stalls, in_ready drops and the result holds.
// Reset clears the architectural registers and empties the output slot. The
// spare RAMs are then cleared by a sweep over their SPARE_BYTES/4 rows (128 by
// default), during which in_ready is low.
// ============================================================================
`default_nettype none

module nand_flash_controller_regs #(
    parameter int SPARE_BYTES = 512,
    parameter int PAGE_BYTES  = 4096,
    parameter int ADDR_CYCLES = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [31:0] bus_address,
    input  wire logic [31:0] write_data,
    input  wire logic [2:0]  width_bytes,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic [2:0]       flash_op,
    output logic [43:0]      flash_offset,
    output logic [1:0]       error_code
);

    localparam int          RowCount   = SPARE_BYTES / 4;
    localparam int          RowW       = $clog2(RowCount);
    localparam logic [12:0] SpareLimit = 13'(SPARE_BYTES);
    localparam logic [14:0] PageMul    = 15'(PAGE_BYTES);
    localparam logic [3:0]  AddrCycles = 4'(ADDR_CYCLES);

    // architectural registers
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] areg_reg [12];
    logic [31:0] areg_next [12];
    logic [31:0] cfg1_reg, cfg1_next, ecc_reg, ecc_next, stat_reg, stat_next;
    logic [31:0] launch_reg, launch_next, wp_reg, wp_next;
    logic [31:0] unlk_reg [8];
    logic [31:0] unlk_next [8];
    logic [31:0] cfg2_reg, cfg2_next, cfg3_reg, cfg3_next;
    logic [31:0] buserr_reg, buserr_next, dly_reg, dly_next;
    logic        irq_reg, irq_next, creq_reg, creq_next;
    logic [7:0]  lat_reg [8];
    logic [7:0]  lat_next [8];
    logic [3:0]  aidx_reg, aidx_next;
    logic [30:0] sdo_reg, sdo_next, sco_reg, sco_next;

    // clear sweep of the spare RAMs
    logic            clr_reg, clr_next;
    logic [RowW-1:0] crow_reg, crow_next;

    // output slot
    logic                 ov_reg;
    logic [31:0]          rd_reg;
    nfcr_pkg::flash_op_t  op_reg;
    logic [43:0]          foff_reg;
    nfcr_pkg::err_t       err_reg;
    logic                 sprd_reg;
    logic [3:0]           spv_reg;
    logic [1:0]           sbase_reg;

    logic                 accept;
    logic [31:0]          rd_c;
    nfcr_pkg::flash_op_t  op_c;
    logic [43:0]          foff_c;
    nfcr_pkg::err_t       err_c;
    logic                 sprd_c;
    logic [3:0]           spv_c;

    logic            bank_we [4];
    logic            bank_re [4];
    logic [RowW-1:0] bank_row [4];
    logic [7:0]      bank_wd [4];
    logic [7:0]      bank_q [4];

    function automatic logic [43:0] decode_off(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [7:0] b4);
        logic [11:0] col;
        logic [18:0] row;
        logic [33:0] prod;
        col  = {b1[3:0], b0};
        row  = {b4[2:0], b3, b2};
        prod = 34'(row) * 34'(PageMul);
        return 44'(prod) + 44'(col);
    endfunction

    assign in_ready = !clr_reg && (!ov_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [31:0] mask;
        logic        wok;
        logic [31:0] val;
        logic        in_buf;
        logic [11:0] s;
        logic        sp_hit;
        logic [11:0] kk;
        logic [31:0] roff;
        logic [31:0] rr;
        logic [31:0] rd;
        logic [43:0] dec_lat;
        logic [43:0] dec_auto;
        logic [46:0] erase_p;
        logic        lerr;
        logic [1:0]  ib;
        logic [12:0] pos;

        cmd_next    = cmd_reg;
        areg_next   = areg_reg;
        cfg1_next   = cfg1_reg;
        ecc_next    = ecc_reg;
        stat_next   = stat_reg;
        launch_next = launch_reg;
        wp_next     = wp_reg;
        unlk_next   = unlk_reg;
        cfg2_next   = cfg2_reg;
        cfg3_next   = cfg3_reg;
        buserr_next = buserr_reg;
        dly_next    = dly_reg;
        irq_next    = irq_reg;
        creq_next   = creq_reg;
        lat_next    = lat_reg;
        aidx_next   = aidx_reg;
        sdo_next    = sdo_reg;
        sco_next    = sco_reg;

        unique case (width_bytes)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd4:    mask = 32'hFFFF_FFFF;
            default: mask = 32'h0;
        endcase
        wok    = (mask != 32'h0);
        val    = write_data & mask;
        in_buf = (bus_address[31:12] == nfcr_pkg::BufWinBase[31:12]);
        s      = bus_address[11:0];
        sp_hit = in_buf && ({1'b0, s} < SpareLimit);
        kk     = s - nfcr_pkg::BufAddrLo;
        roff   = bus_address - nfcr_pkg::IpBase;
        rr     = roff - nfcr_pkg::RegUnlkLo;

        dec_lat  = decode_off(lat_reg[0], lat_reg[1], lat_reg[2], lat_reg[3], lat_reg[4]);
        dec_auto = decode_off(areg_reg[0][7:0], areg_reg[0][15:8], areg_reg[0][23:16],
                              areg_reg[0][31:24], areg_reg[8][7:0]);
        erase_p  = 47'(areg_reg[0]) * 47'(PageMul);

        rd     = 32'h0;
        op_c   = nfcr_pkg::OP_NONE;
        foff_c = 44'h0;
        err_c  = nfcr_pkg::ERR_OK;
        lerr   = 1'b0;

        if (!wok)
        begin
            err_c = nfcr_pkg::ERR_ACCESS;
        end
        else if (in_buf)
        begin
            if (sp_hit)
            begin
                rd = 32'h0;
            end
            else if (s >= nfcr_pkg::BufAddrLo && s <= nfcr_pkg::BufAddrHi)
            begin
                if (action)
                    areg_next[kk[5:2]] = val;
                else
                    rd = areg_reg[kk[5:2]];
            end
            else if (s == nfcr_pkg::BufCmd)
            begin
                if (action)
                    cmd_next = val[7:0];
                else
                    rd = {24'h0, cmd_reg};
            end
            else if (s == nfcr_pkg::BufCfg1)
            begin
                if (action)
                    cfg1_next = val;
                else
                    rd = cfg1_reg;
            end
            else if (s == nfcr_pkg::BufEcc)
            begin
                if (action)
                    ecc_next = val;
                else
                    rd = ecc_reg;
            end
            else if (s == nfcr_pkg::BufStat)
            begin
                if (action)
                    stat_next = val;
                else
                    rd = stat_reg;
            end
            else if (s == nfcr_pkg::BufLaunch)
            begin
                if (!action)
                begin
                    rd = launch_reg;
                end
                else
                begin
                    launch_next = val;
                    if (val[0])
                    begin
                        unique case (cmd_reg)
                            nfcr_pkg::CmdRead, nfcr_pkg::CmdReadId:
                                aidx_next = 4'd0;
                            nfcr_pkg::CmdReadGo, nfcr_pkg::CmdStatus:
                                lerr = 1'b0;
                            nfcr_pkg::CmdCacheSeq:
                            begin
                                sco_next = sdo_reg;
                                sdo_next = sdo_reg + 31'(PAGE_BYTES);
                            end
                            nfcr_pkg::CmdCacheEnd:
                                sco_next = sdo_reg;
                            nfcr_pkg::CmdReset:
                            begin
                                aidx_next = 4'd0;
                                sdo_next  = 31'h0;
                                sco_next  = 31'h0;
                            end
                            default:
                                lerr = 1'b1;
                        endcase
                    end
                    else if (val[1])
                    begin
                        if (aidx_reg < AddrCycles)
                        begin
                            lat_next[aidx_reg[2:0]] = areg_reg[0][7:0];
                            aidx_next = aidx_reg + 4'd1;
                        end
                    end
                    else if (val[5:3] != 3'd0)
                    begin
                        if (val[5:3] == nfcr_pkg::FdoId)
                        begin
                            op_c = nfcr_pkg::OP_ID;
                        end
                        else if (val[5:3] == nfcr_pkg::FdoPage)
                        begin
                            op_c = nfcr_pkg::OP_READ;
                            if (cmd_reg == nfcr_pkg::CmdCacheSeq ||
                                cmd_reg == nfcr_pkg::CmdCacheEnd)
                                foff_c = {13'h0, sco_reg};
                            else
                                foff_c = dec_lat;
                        end
                        else if (val[5:3] == nfcr_pkg::FdoStatus)
                        begin
                            cfg1_next[23:16] = nfcr_pkg::StatusByte;
                        end
                        else
                        begin
                            lerr = 1'b1;
                        end
                    end
                    else if (val[7])
                    begin
                        if (cfg1_reg[11:8] != 4'h0)
                        begin
                            lerr = 1'b1;
                        end
                        else
                        begin
                            lat_next[0] = areg_reg[0][7:0];
                            lat_next[1] = areg_reg[0][15:8];
                            lat_next[2] = areg_reg[0][23:16];
                            lat_next[3] = areg_reg[0][31:24];
                            lat_next[4] = areg_reg[8][7:0];
                            aidx_next   = AddrCycles;
                            sdo_next    = dec_auto[30:0];
                            op_c        = nfcr_pkg::OP_READ;
                            foff_c      = {13'h0, dec_auto[30:0]};
                        end
                    end
                    else if (val[6])
                    begin
                        op_c   = nfcr_pkg::OP_PROG;
                        foff_c = dec_auto;
                    end
                    else if (val[9])
                    begin
                        op_c   = nfcr_pkg::OP_ERASE;
                        foff_c = erase_p[43:0];
                    end
                    else if (val[2] || val[13:6] != 8'h0)
                    begin
                        lerr = 1'b1;
                    end

                    if (lerr)
                    begin
                        err_c       = nfcr_pkg::ERR_LAUNCH;
                        cmd_next    = cmd_reg;
                        cfg1_next   = cfg1_reg;
                        lat_next    = lat_reg;
                        aidx_next   = aidx_reg;
                        sdo_next    = sdo_reg;
                        sco_next    = sco_reg;
                    end
                    else
                    begin
                        irq_next = 1'b1;
                    end
                end
            end
            else
            begin
                err_c = nfcr_pkg::ERR_ACCESS;
            end
        end
        else
        begin
            if (roff >= nfcr_pkg::RegUnlkLo && roff <= nfcr_pkg::RegUnlkHi)
            begin
                if (action)
                    unlk_next[rr[4:2]] = val;
                else
                    rd = unlk_reg[rr[4:2]];
            end
            else if (roff == nfcr_pkg::RegWp)
            begin
                if (action)
                    wp_next = val;
                else
                    rd = wp_reg;
            end
            else if (roff == nfcr_pkg::RegCfg2)
            begin
                if (action)
                    cfg2_next = val;
                else
                    rd = cfg2_reg;
            end
            else if (roff == nfcr_pkg::RegCfg3)
            begin
                if (action)
                    cfg3_next = val;
                else
                    rd = cfg3_reg;
            end
            else if (roff == nfcr_pkg::RegIrq)
            begin
                if (action)
                begin
                    irq_next  = val[31];
                    creq_next = val[0];
                end
                else
                begin
                    rd = {irq_reg, 2'b00, 1'b1, 26'h0, creq_reg, creq_reg};
                end
            end
            else if (roff == nfcr_pkg::RegBusErr)
            begin
                if (action)
                    buserr_next = val;
                else
                    rd = buserr_reg;
            end
            else if (roff == nfcr_pkg::RegDelay)
            begin
                if (action)
                    dly_next = val;
                else
                    rd = dly_reg;
            end
            else
            begin
                err_c = nfcr_pkg::ERR_ACCESS;
            end
        end

        if (err_c != nfcr_pkg::ERR_OK)
        begin
            op_c   = nfcr_pkg::OP_NONE;
            foff_c = 44'h0;
        end
        if (err_c != nfcr_pkg::ERR_OK || action)
            rd_c = 32'h0;
        else
            rd_c = rd & mask;

        sprd_c = wok && sp_hit && !action;
        for (int i = 0; i < 4; i++)
        begin
            pos      = {1'b0, s} + 13'(i);
            spv_c[i] = (3'(i) < width_bytes) && (pos < SpareLimit);
        end

        for (int b = 0; b < 4; b++)
        begin
            ib          = 2'(b) - s[1:0];
            pos         = {1'b0, s} + {11'h0, ib};
            bank_wd[b]  = 8'(val >> {ib, 3'b000});
            bank_we[b]  = 1'b0;
            bank_re[b]  = 1'b0;
            bank_row[b] = pos[RowW+1:2];
            if (clr_reg)
            begin
                bank_we[b]  = 1'b1;
                bank_wd[b]  = 8'h0;
                bank_row[b] = crow_reg;
            end
            else if (accept && wok && sp_hit && ({1'b0, ib} < width_bytes) &&
                     (pos < SpareLimit))
            begin
                bank_we[b] = action;
                bank_re[b] = !action;
            end
        end

        clr_next  = clr_reg && (crow_reg != RowW'(RowCount - 1));
        crow_next = crow_reg + RowW'(1);
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        nfcr_ram #(
            .WIDTH (8),
            .DEPTH (RowCount)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[g]),
            .re    (bank_re[g]),
            .addr  (bank_row[g]),
            .wdata (bank_wd[g]),
            .rdata (bank_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= 1'b1;
            crow_reg <= '0;
        end
        else
        begin
            clr_reg  <= clr_next;
            crow_reg <= crow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg    <= 8'h0;
            cfg1_reg   <= 32'h0;
            ecc_reg    <= 32'h0;
            stat_reg   <= 32'h0;
            launch_reg <= 32'h0;
            wp_reg     <= 32'h0;
            cfg2_reg   <= 32'h0;
            cfg3_reg   <= 32'h0;
            buserr_reg <= 32'h0;
            dly_reg    <= 32'h0;
            irq_reg    <= 1'b0;
            creq_reg   <= 1'b0;
            aidx_reg   <= 4'h0;
            sdo_reg    <= 31'h0;
            sco_reg    <= 31'h0;
            for (int i = 0; i < 12; i++)
            begin
                areg_reg[i] <= 32'h0;
            end
            for (int i = 0; i < 8; i++)
            begin
                unlk_reg[i] <= 32'h0;
                lat_reg[i]  <= 8'h0;
            end
        end
        else if (accept)
        begin
            cmd_reg    <= cmd_next;
            areg_reg   <= areg_next;
            cfg1_reg   <= cfg1_next;
            ecc_reg    <= ecc_next;
            stat_reg   <= stat_next;
            launch_reg <= launch_next;
            wp_reg     <= wp_next;
            unlk_reg   <= unlk_next;
            cfg2_reg   <= cfg2_next;
            cfg3_reg   <= cfg3_next;
            buserr_reg <= buserr_next;
            dly_reg    <= dly_next;
            irq_reg    <= irq_next;
            creq_reg   <= creq_next;
            lat_reg    <= lat_next;
            aidx_reg   <= aidx_next;
            sdo_reg    <= sdo_next;
            sco_reg    <= sco_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (accept)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg    <= rd_c;
            op_reg    <= op_c;
            foff_reg  <= foff_c;
            err_reg   <= err_c;
            sprd_reg  <= sprd_c;
            spv_reg   <= spv_c;
            sbase_reg <= bus_address[1:0];
        end
    end

    always_comb
    begin
        logic [31:0] sw;
        logic [1:0]  lane;
        sw = 32'h0;
        for (int i = 0; i < 4; i++)
        begin
            lane = sbase_reg + 2'(i);
            if (spv_reg[i])
                sw[8*i +: 8] = bank_q[lane];
        end
        read_data = sprd_reg ? sw : rd_reg;
    end

    assign out_valid    = ov_reg;
    assign flash_op     = op_reg;
    assign flash_offset = foff_reg;
    assign error_code   = err_reg;

    a_err_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != nfcr_pkg::ERR_OK |->
            flash_op == nfcr_pkg::OP_NONE && flash_offset == 44'h0)
        else $error("error result carries a flash request");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("transaction accepted while result stalled");

    a_id_no_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flash_op == nfcr_pkg::OP_ID |-> flash_offset == 44'h0)
        else $error("ID output with nonzero offset");

endmodule

`default_nettype wire
